FILE: sv/binned_visibility_integrate_dump_assert.svh
// Assertion macros shared by the integrate-and-dump RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BINNED_VISIBILITY_INTEGRATE_DUMP_ASSERT_SVH
`define BINNED_VISIBILITY_INTEGRATE_DUMP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BVID_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define BVID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define BVID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bvid_pkg.sv
// Types and fixed field widths of the binned visibility integrate-and-dump block.
// No dependencies; imported by the top-level RTL module and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bvid_pkg;

  localparam int unsigned BIN_W  = 3;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CHAN_W = 6;
  localparam int unsigned POL_W  = 2;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_EOD    = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [BIN_W-1:0]         bin;
    logic [SLOT_W-1:0]        slot;
    logic [CHAN_W-1:0]        chan;
    logic [POL_W-1:0]         pol;
    logic signed [DATA_W-1:0] re_in;
    logic signed [DATA_W-1:0] im_in;
  } bvid_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]         out_bin;
    logic [SLOT_W-1:0]        out_slot;
    logic [CHAN_W-1:0]        out_chan;
    logic [POL_W-1:0]         out_pol;
    logic signed [DATA_W-1:0] re_out;
    logic signed [DATA_W-1:0] im_out;
  } bvid_out_t;

  // One accumulator entry: real and imaginary running sums.
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

endpackage

`default_nettype wire

FILE: sv/bvid_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type is a parameter; the block uses the structs of bvid_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bvid_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: sv/bvid_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the accumulator store.
`timescale 1ns / 1ps
`default_nettype none

module bvid_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/binned_visibility_integrate_dump.sv
// Top level of the binned visibility integrate-and-dump block.
// Depends on bvid_pkg, bvid_stream_if, bvid_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat per clock cycle on in_i unless a held output stalls it,
// and gives at most one beat on out_o for each input beat, via the stage 1 and
// output registers. A bin 0 sample leaves conjugated right away; a sample of bin j
// of 1 or more is added into its accumulator entry (imaginary part negated) and
// only on the last dump of each run of 2^j dumps is the entry plus the sample sent
// and the entry cleared. The throughput is set by the read-modify-write loop
// through the one accumulator RAM: the read is issued at acceptance, the sum is
// formed and written back as stage 1 advances, and a forward register covers a
// sample that hits the entry written in the cycle its own read was issued. After
// reset the block clears the accumulator RAM one entry per cycle and accepts no
// beat until all (NUM_BINS-1) * 2^(tag bits) entries, 32768 with the default
// parameters, are cleared. The RAM is addressed by the concatenation of bin minus
// one, slot, channel and polarization, each tag at the width that its range needs.
module binned_visibility_integrate_dump
  import bvid_pkg::*;
#(
  parameter int unsigned NUM_BINS      = 5,
  parameter int unsigned SLOTS_PER_BIN = 32,
  parameter int unsigned NUM_CHANS     = 64,
  parameter int unsigned NUM_POLS      = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bvid_stream_if.sink   in_i,
  bvid_stream_if.source out_o
);

  `include "binned_visibility_integrate_dump_assert.svh"

  // Address layout. Tags never exceed their port widths, so each address field
  // is capped at that width.
  localparam int unsigned SLOT_AW = (SLOTS_PER_BIN >= 32) ? SLOT_W :
                                    ((SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1);
  localparam int unsigned CHAN_AW = (NUM_CHANS >= 64) ? CHAN_W :
                                    ((NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1);
  localparam int unsigned POL_AW  = (NUM_POLS > 2) ? POL_W : 1;
  localparam int unsigned TAG_W   = SLOT_AW + CHAN_AW + POL_AW;
  localparam int unsigned DEPTH   = (NUM_BINS - 1) * (1 << TAG_W);
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CNT_W   = NUM_BINS - 1;
  localparam int unsigned BIDX_W  = $clog2(NUM_BINS);
  localparam int unsigned RAM_W   = $bits(cplx_t);

  // Clearing pass after reset.
  logic          clear_q;
  logic [AW-1:0] clr_cnt_q;

  // Dump counters and send flags for bins 1 and up; bin 0 always sends.
  logic [CNT_W-1:0]    cnt_q  [NUM_BINS-1:1];
  logic [CNT_W-1:0]    cnt_d  [NUM_BINS-1:1];
  logic [NUM_BINS-1:1] send_q;
  logic [NUM_BINS-1:1] send_d;
  logic [NUM_BINS-1:0] send_vec;

  // Accept side.
  logic                   in_fire;
  logic                   is_eod;
  logic                   in_range;
  logic [TAG_W-1:0]       in_tag;
  logic [BIN_W+TAG_W-1:0] in_addr_full;
  logic [AW-1:0]          rd_addr;

  // Stage 1: the sample whose accumulator entry is arriving from the RAM.
  logic          s1_valid_q;
  logic          s1_bin0_q;
  logic          s1_send_q;
  logic [AW-1:0] s1_addr_q;
  bvid_in_t      s1_item_q;
  logic          s1_emit;
  logic          s1_adv;
  logic          s1_fire;

  // RAM ports and the forward register.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cplx_t         ram_wdata;
  cplx_t         ram_rdata;
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  cplx_t         fwd_data_q;
  logic          fwd_hit;
  cplx_t         base;
  logic signed [DATA_W-1:0] sum_re;
  logic signed [DATA_W-1:0] sum_im;

  // Output register.
  logic      out_valid_q;
  bvid_out_t out_q;
  logic      out_free;

  // ---------------------------------------------------------------------------
  // Accept side: range check, flag lookup and RAM read address.
  // ---------------------------------------------------------------------------
  assign send_vec = {send_q, 1'b1};
  assign in_fire  = in_i.valid && in_i.ready;
  assign is_eod   = (in_i.data.kind == KIND_EOD);
  assign in_range = (32'(in_i.data.bin)  < NUM_BINS)      &&
                    (32'(in_i.data.slot) < SLOTS_PER_BIN) &&
                    (32'(in_i.data.chan) < NUM_CHANS)     &&
                    (32'(in_i.data.pol)  < NUM_POLS);

  assign in_tag       = {in_i.data.slot[SLOT_AW-1:0], in_i.data.chan[CHAN_AW-1:0],
                         in_i.data.pol[POL_AW-1:0]};
  assign in_addr_full = {in_i.data.bin - BIN_W'(1), in_tag};
  assign rd_addr      = in_addr_full[AW-1:0];

  // ---------------------------------------------------------------------------
  // Stage 1 flow control. A stage 1 sample that gives no result moves on even
  // while the output register is held, so the input keeps flowing.
  // ---------------------------------------------------------------------------
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_emit     = s1_valid_q && (s1_bin0_q || s1_send_q);
  assign s1_adv      = !s1_emit || out_free;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign in_i.ready  = !clear_q && s1_adv;

  // ---------------------------------------------------------------------------
  // Read-modify-write. The entry written at the edge that issued this sample's
  // read is not yet in the RAM read data, so it comes from the forward register.
  // ---------------------------------------------------------------------------
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_addr_q);

  always_comb begin
    if (s1_bin0_q) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_data_q;
    end else begin
      base = ram_rdata;
    end
  end

  assign sum_re = base.re + s1_item_q.re_in;
  assign sum_im = base.im - s1_item_q.im_in;

  // Sending an entry empties it; the clearing pass writes zeros as well.
  assign ram_we    = clear_q || (s1_fire && !s1_bin0_q);
  assign ram_waddr = clear_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = (clear_q || s1_send_q) ? cplx_t'('0) : cplx_t'{re: sum_re, im: sum_im};

  bvid_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // The forward register records the write of the edge at which a read is issued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ram_we || in_fire) begin
      fwd_valid_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= ram_waddr;
      fwd_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clear_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // End-of-dump marker: a bin that has just sent starts a new run, any other
  // bin counts one more dump and arms its send flag for the last dump of the run.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 1; j < NUM_BINS; j++) begin
      cnt_d[j]  = cnt_q[j];
      send_d[j] = send_q[j];
      if (send_q[j]) begin
        send_d[j] = 1'b0;
        cnt_d[j]  = '0;
      end else begin
        cnt_d[j] = cnt_q[j] + CNT_W'(1);
        if (({1'b0, cnt_q[j]} + (CNT_W + 1)'(2)) == ((CNT_W + 1)'(1) << j)) begin
          send_d[j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 1; j < NUM_BINS; j++) begin
        cnt_q[j] <= '0;
      end
      send_q <= '0;
    end else if (in_fire && is_eod) begin
      for (int j = 1; j < NUM_BINS; j++) begin
        cnt_q[j] <= cnt_d[j];
      end
      send_q <= send_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers. Markers and ignored samples leave stage 1 empty.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_fire && !is_eod && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.data;
      s1_addr_q <= rd_addr;
      s1_bin0_q <= (in_i.data.bin == '0);
      s1_send_q <= send_vec[in_i.data.bin[BIDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      out_q.out_bin  <= s1_item_q.bin;
      out_q.out_slot <= s1_item_q.slot;
      out_q.out_chan <= s1_item_q.chan;
      out_q.out_pol  <= s1_item_q.pol;
      out_q.re_out   <= sum_re;
      out_q.im_out   <= sum_im;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `BVID_ASSERT_IMPL(a_no_accept_in_clear, clear_q, !in_i.ready,
                    "input accepted during the clearing pass")
  `BVID_ASSERT_IMPL(a_clear_writes_zero, clear_q, ram_we && (ram_wdata == cplx_t'('0)),
                    "clearing pass did not write zero")
  `BVID_ASSERT_IMPL(a_sample_write_src, ram_we && !clear_q, s1_valid_q && !s1_bin0_q,
                    "accumulator written without a binned sample in stage 1")
  `BVID_ASSERT_NEXT(a_s1_held_on_stall, s1_emit && out_valid_q && !out_o.ready,
                    s1_valid_q && $stable(s1_addr_q) && $stable(s1_send_q),
                    "stage 1 result lost while the output was stalled")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for binned_visibility_integrate_dump, top module tb_top.
// Depends on bvid_pkg, bvid_stream_if and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import bvid_pkg::*;

  // Block configuration. It must match the parameters passed to u_top below.
  localparam int unsigned NUM_BINS      = 5;
  localparam int unsigned SLOTS_PER_BIN = 32;
  localparam int unsigned NUM_CHANS     = 64;
  localparam int unsigned NUM_POLS      = 4;

  // Number of baseline tags that the random dump sequences revisit. A small
  // pool makes samples land on entries that already hold a running sum, and
  // often on the entry that the previous beat has just written.
  localparam int POOL_SIZE = 8;

  // Cycles allowed after the last result for beats that give no result to
  // leave the pipeline, and the cap on any wait for outstanding results.
  localparam int PIPE_SETTLE = 8;
  localparam int DRAIN_LIMIT = 20000;

  // Run limit in nanoseconds. A correct run needs the clearing pass after reset
  // plus the time that the beats take, far less than this limit.
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // Ways the result receiver drives ready between forced hold-offs.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_CADENCE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  bvid_stream_if #(.T(bvid_in_t))  in_if ();
  bvid_stream_if #(.T(bvid_out_t)) out_if ();

  binned_visibility_integrate_dump #(
    .NUM_BINS     (NUM_BINS),
    .SLOTS_PER_BIN(SLOTS_PER_BIN),
    .NUM_CHANS    (NUM_CHANS),
    .NUM_POLS     (NUM_POLS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state. The accumulator is kept sparse: an entry that is absent
  // holds zero, which is also what the block's clearing pass leaves behind.
  // dump_phase and dump_due follow the per-bin dump counter and send flag.
  // ---------------------------------------------------------------------------
  cplx_t       acc_sums [int unsigned];
  int unsigned dump_phase [NUM_BINS] = '{default: 0};
  bit          dump_due [NUM_BINS]   = '{default: 1'b0};
  bvid_out_t   expected_sums [$];

  int err_count = 0;

  // Sender and receiver pacing, shared between the test tasks and the
  // processes that drive the handshakes.
  bit sender_eager   = 1'b0;
  int burst_left     = 0;
  int rx_hold_cycles = 0;

  // Tag pool used by the random dump sequences.
  logic [BIN_W-1:0]  pool_bin  [POOL_SIZE];
  logic [SLOT_W-1:0] pool_slot [POOL_SIZE];
  logic [CHAN_W-1:0] pool_chan [POOL_SIZE];
  logic [POL_W-1:0]  pool_pol  [POOL_SIZE];

  // ---------------------------------------------------------------------------
  // Clock: 20 ns period.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run, in case the block stops handshaking.
  initial begin
    #(TIMEOUT_NS);
    $display("[binned_visibility_integrate_dump] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Every failure goes through here; printing is capped so
  // that a badly broken block cannot flood the log, but every failure counts.
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      report_error($sformatf("%s expected %h, got %h", name, want, got));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Predictor. Called once for every beat that the block accepts, in order.
  // A marker advances the dump phase of every integrating bin. A valid sample
  // of bin 0 is conjugated and sent at once. A sample of a higher bin is added
  // into its entry with the imaginary part negated; on the last dump of the
  // bin's period the new sum is sent instead and the entry goes back to zero.
  // All arithmetic is at 32 bits, so sums and the negation of the most
  // negative value wrap just as in the block.
  // ---------------------------------------------------------------------------
  function automatic void predict_beat(input bvid_in_t beat);
    int unsigned key;
    cplx_t       acc;
    bvid_out_t   res;

    if (beat.kind == KIND_EOD) begin
      for (int j = 1; j < NUM_BINS; j++) begin
        if (dump_due[j]) begin
          dump_due[j]   = 1'b0;
          dump_phase[j] = 0;
        end else begin
          dump_phase[j]++;
          if (dump_phase[j] + 1 == (1 << j)) begin
            dump_due[j] = 1'b1;
          end
        end
      end
      return;
    end

    // Samples whose bin or tags fall outside the configured ranges are dropped.
    if (beat.bin >= NUM_BINS || beat.slot >= SLOTS_PER_BIN ||
        beat.chan >= NUM_CHANS || beat.pol >= NUM_POLS) begin
      return;
    end

    res.out_bin  = beat.bin;
    res.out_slot = beat.slot;
    res.out_chan = beat.chan;
    res.out_pol  = beat.pol;

    if (beat.bin == 0) begin
      res.re_out = beat.re_in;
      res.im_out = -beat.im_in;
    end else begin
      key = (((beat.bin - 1) * SLOTS_PER_BIN + beat.slot) * NUM_CHANS + beat.chan)
            * NUM_POLS + beat.pol;
      acc    = acc_sums.exists(key) ? acc_sums[key] : '0;
      acc.re = acc.re + beat.re_in;
      acc.im = acc.im - beat.im_in;
      if (!dump_due[beat.bin]) begin
        acc_sums[key] = acc;
        return;
      end
      acc_sums.delete(key);
      res.re_out = acc.re;
      res.im_out = acc.im;
    end
    expected_sums.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. Every output beat is matched against the oldest expected
  // sum, field by field. Inputs and outputs are sampled right after the edge,
  // before any nonblocking update of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bvid_out_t oldest;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_sums.size() == 0) begin
        report_error($sformatf("unexpected output beat bin %0d slot %0d chan %0d pol %0d",
                               out_if.data.out_bin, out_if.data.out_slot,
                               out_if.data.out_chan, out_if.data.out_pol));
      end else begin
        oldest = expected_sums.pop_front();
        check_field("out_bin", DATA_W'(oldest.out_bin), DATA_W'(out_if.data.out_bin));
        check_field("out_slot", DATA_W'(oldest.out_slot), DATA_W'(out_if.data.out_slot));
        check_field("out_chan", DATA_W'(oldest.out_chan), DATA_W'(out_if.data.out_chan));
        check_field("out_pol", DATA_W'(oldest.out_pol), DATA_W'(out_if.data.out_pol));
        check_field("re_out", oldest.re_out, out_if.data.re_out);
        check_field("im_out", oldest.im_out, out_if.data.im_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. Ready follows a pattern that changes after each segment of
  // random length: always open, a fair coin, mostly open, or a fixed cadence. A test
  // can request a long hold-off, which this process counts down by itself.
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_e mode;
    int       seg_left;
    int       phase;

    mode     = RX_OPEN;
    seg_left = 0;
    phase    = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (rx_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (mode)
          RX_OPEN: begin
            out_if.ready <= 1'b1;
          end
          RX_COIN: begin
            out_if.ready <= 1'($urandom_range(0, 1));
          end
          RX_MOSTLY: begin
            out_if.ready <= ($urandom_range(0, 4) != 0);
          end
          default: begin
            out_if.ready <= (phase % 3 != 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Beat construction helpers.
  // ---------------------------------------------------------------------------

  // Data words lean on the extremes so that the wrapping paths are hit often.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic bvid_in_t sample_beat(input logic [BIN_W-1:0] b,
                                           input logic [SLOT_W-1:0] s,
                                           input logic [CHAN_W-1:0] c,
                                           input logic [POL_W-1:0] p,
                                           input logic [DATA_W-1:0] re,
                                           input logic [DATA_W-1:0] im);
    bvid_in_t beat;
    beat.kind  = KIND_SAMPLE;
    beat.bin   = b;
    beat.slot  = s;
    beat.chan  = c;
    beat.pol   = p;
    beat.re_in = re;
    beat.im_in = im;
    return beat;
  endfunction

  // A marker carries random junk in every other field; the block ignores it.
  function automatic bvid_in_t eod_beat();
    bvid_in_t beat;
    beat      = sample_beat(BIN_W'($urandom), SLOT_W'($urandom), CHAN_W'($urandom),
                            POL_W'($urandom), $urandom, $urandom);
    beat.kind = KIND_EOD;
    return beat;
  endfunction

  // Bin 0 is drawn less often so that most pool tags integrate.
  function automatic void refresh_tag(input int idx);
    pool_bin[idx]  = ($urandom_range(0, 4) == 0) ? '0 : BIN_W'($urandom_range(1, NUM_BINS - 1));
    pool_slot[idx] = SLOT_W'($urandom);
    pool_chan[idx] = CHAN_W'($urandom);
    pool_pol[idx]  = POL_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Drives one beat and returns at the edge where it is accepted. In
  // the normal mode it works in bursts of random length with random gaps in
  // between; in eager mode it offers beats back to back.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input bvid_in_t beat);
    int gap;
    if (!sender_eager) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_if.valid <= 1'b1;
    in_if.data  <= beat;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    predict_beat(beat);
  endtask

  // Stops offering beats until every expected sum has come back, then lets
  // the pipeline settle so that beats without a result have left it too.
  task automatic wait_drained();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_sums.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_sums.size() != 0) begin
      report_error($sformatf("%0d expected sums never arrived", expected_sums.size()));
    end
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  // Well-formed dump sequences: a run of samples drawn mostly from the tag
  // pool, closed by an end-of-dump marker. About one sample in ten is noise:
  // a random tag, an out-of-range bin, or a stray marker that cuts the dump
  // short. The same tag is often repeated on consecutive beats so that the
  // read-modify-write forwarding in the block is exercised.
  task automatic run_dumps(input int n_dumps);
    int       n_samples;
    int       pick;
    int       last_pick;
    bvid_in_t beat;

    last_pick = 0;
    for (int d = 0; d < n_dumps; d++) begin
      if ($urandom_range(0, 2) == 0) begin
        refresh_tag($urandom_range(0, POOL_SIZE - 1));
      end
      n_samples = $urandom_range(0, 20);
      for (int k = 0; k < n_samples; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            beat = eod_beat();
          end else begin
            beat = sample_beat(BIN_W'($urandom_range(0, 7)), SLOT_W'($urandom),
                               CHAN_W'($urandom), POL_W'($urandom),
                               rand_word(), rand_word());
          end
        end else begin
          pick      = ($urandom_range(0, 5) == 0) ? last_pick
                                                  : $urandom_range(0, POOL_SIZE - 1);
          last_pick = pick;
          beat      = sample_beat(pool_bin[pick], pool_slot[pick], pool_chan[pick],
                                  pool_pol[pick], rand_word(), rand_word());
        end
        send_beat(beat);
      end
      send_beat(eod_beat());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Bin 0 samples leave at once, conjugated, with the tags at both extremes.
  // The most negative imaginary part must come back unchanged.
  task automatic test_bin0_conjugate();
    sender_eager = 1'b1;
    send_beat(sample_beat(3'd0, 5'd0, 6'd0, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(sample_beat(3'd0, 5'd31, 6'd63, 2'd3, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(sample_beat(3'd0, 5'd5, 6'd17, 2'd2, 32'h0000_0000, 32'h0000_0000));
    send_beat(sample_beat(3'd0, 5'd31, 6'd0, 2'd1, 32'hFFFF_FFFF, 32'h0000_0001));
  endtask

  // Samples of the bins above the last one are dropped without a trace.
  task automatic test_ignored_bins();
    sender_eager = 1'b1;
    for (int b = NUM_BINS; b < (1 << BIN_W); b++) begin
      send_beat(sample_beat(BIN_W'(b), SLOT_W'($urandom), CHAN_W'($urandom),
                            POL_W'($urandom), rand_word(), rand_word()));
    end
  endtask

  // Bin 1 integrates over two dumps. Two back-to-back samples on one entry
  // accumulate with wrapping, a marker opens the sending dump, and then two
  // back-to-back samples on that entry each come out: the second one must see
  // the entry already cleared by the first. The closing marker has every
  // ignored field set.
  task automatic test_accumulate_and_dump();
    bvid_in_t marker;
    sender_eager = 1'b1;
    send_beat(sample_beat(3'd1, 5'd3, 6'd10, 2'd1, 32'h7FFF_FFFF, 32'h0000_0001));
    send_beat(sample_beat(3'd1, 5'd3, 6'd10, 2'd1, 32'h0000_0001, 32'h8000_0000));
    send_beat(sample_beat(3'd4, 5'd3, 6'd10, 2'd1, 32'h1234_5678, 32'h8765_4321));
    send_beat(eod_beat());
    send_beat(sample_beat(3'd1, 5'd3, 6'd10, 2'd1, 32'h0000_0001, 32'h0000_0001));
    send_beat(sample_beat(3'd1, 5'd3, 6'd10, 2'd1, 32'h8000_0000, 32'h8000_0000));
    send_beat(sample_beat(3'd1, 5'd31, 6'd63, 2'd3, 32'h8000_0000, 32'h8000_0000));
    marker      = '1;
    marker.kind = KIND_EOD;
    send_beat(marker);
  endtask

  // The bulk of the run: many dump periods of every bin with random pacing.
  task automatic test_random_dumps();
    sender_eager = 1'b0;
    run_dumps(100);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats back to back, so the block fills up and must stall its input.
  task automatic test_output_backpressure();
    sender_eager   = 1'b1;
    rx_hold_cycles = 400;
    run_dumps(10);
    sender_eager = 1'b0;
  endtask

  // The sender stops until every result is back, several times, so that the
  // block restarts from an empty pipeline in the middle of dump periods.
  task automatic test_paused_sender();
    sender_eager = 1'b0;
    for (int r = 0; r < 4; r++) begin
      run_dumps(3);
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence. Reset is held and then released; the block then runs its
  // clearing pass with its input stalled, which the first beat waits out.
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    out_if.ready <= 1'b0;
    rst_ni       <= 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      refresh_tag(i);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_bin0_conjugate();
    test_ignored_bins();
    test_accumulate_and_dump();
    test_random_dumps();
    test_output_backpressure();
    test_paused_sender();
    wait_drained();

    if (err_count == 0) begin
      $display("[binned_visibility_integrate_dump] OK");
    end else begin
      $display("[binned_visibility_integrate_dump] ERROR");
    end
    $finish;
  end

endmodule
